// ===== hw/rtl/assert_macros.svh =====
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that holds at every clock while out of reset
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m: label");
// implication checked from one edge to the next
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: label");
`endif

// ===== hw/rtl/ted_pkg.sv =====
// ----------------------------------------------------------------------------
// ted_pkg
// shared types and constants of the tilde escape text decompressor
// ----------------------------------------------------------------------------
package ted_pkg;

  localparam int unsigned STORE_DEPTH = 56;
  localparam int unsigned CNT_W       = 6;
  localparam logic [6:0]  RUN_MAX     = 7'd94;

  typedef enum logic [3:0] {
    M_PLAIN, M_ESC, M_SPACES, M_STREAM, M_BUFFER, M_LITERAL
  } mode_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE, S_SPACES, S_STR_HI, S_STR_LO, S_FIN_RD, S_FIN_EMIT, S_FIN_TAIL, S_ESC_BYTE
  } state_t;

  // emission phases of a buffered number
  typedef enum logic [3:0] {
    P_LEAD, P_DOT, P_MID, P_E, P_SIGN, P_EXP, P_TERM, P_DONE
  } phase_t;

  typedef enum logic [1:0] {T_SPACE, T_TILDE, T_FLUSH} term_t;

  typedef struct packed {
    logic [7:0] code;
    logic [1:0] form;
    logic [2:0] lead;
    logic [1:0] tail;
    logic       lit;
    logic [7:0] sign;
  } kind_t;

  function automatic kind_t kind_of(input logic [3:0] k);
    kind_t r;
    case (k)
      4'd1:    r = '{8'h22, 2'd1, 3'd1, 2'd0, 1'b1, 8'h00};
      4'd2:    r = '{8'h25, 2'd1, 3'd4, 2'd0, 1'b1, 8'h00};
      4'd3:    r = '{8'h28, 2'd1, 3'd7, 2'd0, 1'b1, 8'h00};
      4'd4:    r = '{8'h4F, 2'd1, 3'd1, 2'd1, 1'b0, 8'h00};
      4'd5:    r = '{8'h50, 2'd1, 3'd2, 2'd1, 1'b0, 8'h00};
      4'd6:    r = '{8'h54, 2'd1, 3'd6, 2'd1, 1'b0, 8'h00};
      4'd7:    r = '{8'h30, 2'd2, 3'd0, 2'd2, 1'b0, 8'h2B};
      4'd8:    r = '{8'h5D, 2'd2, 3'd0, 2'd3, 1'b0, 8'h2B};
      4'd9:    r = '{8'h31, 2'd2, 3'd1, 2'd2, 1'b0, 8'h2B};
      4'd10:   r = '{8'h40, 2'd2, 3'd1, 2'd2, 1'b0, 8'h2D};
      4'd11:   r = '{8'h5E, 2'd2, 3'd1, 2'd3, 1'b0, 8'h2B};
      default: r = '{8'h4E, 2'd0, 3'd0, 2'd0, 1'b0, 8'h00};
    endcase
    return r;
  endfunction

  // kind index of an escape code, 4'hF when it is none
  function automatic logic [3:0] kind_lookup(input logic [7:0] b);
    logic [3:0] r;
    r = 4'hF;
    for (int i = 0; i < 12; i++) begin
      if (kind_of(4'(i)).code == b) r = 4'(i);
    end
    return r;
  endfunction

  // command from controller to datapath
  typedef struct packed {
    logic       emit;
    logic [7:0] ch;
    logic [6:0] cnt;
    logic       use_digit;
    logic       flag;
  } emit_cmd_t;

endpackage

// ===== hw/rtl/ted_stream_if.sv =====
// ----------------------------------------------------------------------------
// ted_stream_if
// valid/ready channels for input and result items
// ----------------------------------------------------------------------------
interface ted_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       flush;
  modport source (output valid, in_byte, flush, input ready);
  modport sink   (input valid, in_byte, flush, output ready);
endinterface

interface ted_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic [6:0] repeat_count;
  logic       last_of_run;
  logic       digits_dropped;
  modport source (output valid, out_char, repeat_count, last_of_run, digits_dropped,
                  input ready);
  modport sink   (input valid, out_char, repeat_count, last_of_run, digits_dropped,
                  output ready);
endinterface

// ===== hw/rtl/ted_ram.sv =====
// ----------------------------------------------------------------------------
// ted_ram
// generic single write, single read ram with registered read
// ----------------------------------------------------------------------------
module ted_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 56
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/ted_datapath.sv =====
// ----------------------------------------------------------------------------
// ted_datapath
// digit store and result output register
// ----------------------------------------------------------------------------
module ted_datapath import ted_pkg::*; #(
  parameter int MAX_DIGITS = 56
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [CNT_W-1:0]   wr_addr,
  input  logic [3:0]         wr_digit,
  input  logic [CNT_W-1:0]   rd_addr,
  input  emit_cmd_t          cmd,
  input  logic               last,
  output logic               busy,
  ted_out_if.source          out_ch
);
  logic [3:0] rd_digit;

  ted_ram #(.WIDTH(4), .DEPTH(MAX_DIGITS)) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr[$clog2(MAX_DIGITS)-1:0]),
    .wdata (wr_digit),
    .raddr (rd_addr[$clog2(MAX_DIGITS)-1:0]),
    .rdata (rd_digit)
  );

  // output register: loads when empty or taken
  assign busy = out_ch.valid && !out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (!busy) begin
      out_ch.valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!busy && cmd.emit) begin
      out_ch.out_char       <= cmd.use_digit ? (8'h30 | {4'd0, rd_digit}) : cmd.ch;
      out_ch.repeat_count   <= cmd.cnt;
      out_ch.last_of_run    <= last;
      out_ch.digits_dropped <= cmd.flag;
    end
  end
endmodule

// ===== hw/rtl/ted_ctrl.sv =====
// ----------------------------------------------------------------------------
// ted_ctrl
// decode state machine: escapes, pair collection and number emission
// ----------------------------------------------------------------------------
module ted_ctrl import ted_pkg::*; #(
  parameter int MAX_DIGITS = 56
) (
  input  logic             clk,
  input  logic             rst,
  ted_in_if.sink           in_ch,
  input  logic             busy,
  output logic             wr_en,
  output logic [CNT_W-1:0] wr_addr,
  output logic [3:0]       wr_digit,
  output logic [CNT_W-1:0] rd_addr,
  output emit_cmd_t        cmd,
  output logic             last
);
  state_t state, state_next;
  mode_t  mode, mode_next;
  logic [3:0]       kind, kind_next;
  logic [CNT_W-1:0] dcount, dcount_next;
  logic             hpend, hpend_next, ovf, ovf_next;
  // work registers
  logic [7:0]       sp_left, sp_left_next;
  logic [6:0]       pair, pair_next;
  logic             wr_lo, wr_lo_next;
  logic [3:0]       lo_digit, lo_digit_next;
  phase_t           ph, ph_next;
  logic [CNT_W-1:0] pos, pos_next, left, left_next;
  logic [1:0]       term, term_next;
  logic             lit_go, lit_go_next;

  kind_t kd;
  assign kd = kind_of(kind);

  logic acc;
  assign acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state == S_IDLE) && !wr_lo && !busy;

  logic [7:0] b;
  assign b = in_ch.in_byte;

  // pair value of the current byte
  logic [8:0] praw;
  logic [6:0] pval;
  always_comb begin
    praw = hpend ? ({1'b0, b} + 9'd59) : ({1'b0, b} - 9'd33);
    if (!hpend && b < 8'd33) pval = 7'd0;
    else if (praw > 9'd99) pval = 7'd99;
    else pval = praw[6:0];
  end
  logic [3:0] ptens, pones;
  assign ptens = 4'((15'(pval) * 15'd205) >> 11);
  assign pones = 4'(pval - 7'(ptens) * 7'd10);

  // digits of a streamed pair
  logic [3:0] stens, sones;
  assign stens = 4'((15'(pair) * 15'd205) >> 11);
  assign sones = 4'(pair - 7'(stens) * 7'd10);

  // counts of the current buffered layout
  logic [CNT_W:0] sum_lt;
  logic [CNT_W-1:0] after;
  assign sum_lt = (CNT_W+1)'(kd.lead) + (CNT_W+1)'(kd.tail);
  assign after = ({1'b0, dcount} > sum_lt) ? CNT_W'({1'b0, dcount} - sum_lt) : '0;

  // length of a phase in digits
  function automatic logic [CNT_W-1:0] phase_len(input phase_t p, input kind_t k,
      input logic [CNT_W-1:0] n, input logic [CNT_W-1:0] a);
    logic [CNT_W-1:0] r;
    case (p)
      P_LEAD:  r = (k.form == 2'd0) ? ((n != 0) ? n - 1'b1 : '0)
                 : (k.form == 2'd1) ? CNT_W'(k.lead) : CNT_W'(k.lead);
      P_MID:   r = a;
      P_EXP:   r = CNT_W'(2);
      default: r = '0;
    endcase
    return r;
  endfunction

  // following phase
  function automatic phase_t phase_after(input phase_t p, input kind_t k);
    phase_t r;
    case (p)
      P_LEAD:  r = (k.form == 2'd0) ? P_TERM : ((k.form == 2'd2 && k.lead == 0) ? P_MID
                                                                               : P_DOT);
      P_DOT:   r = P_MID;
      P_MID:   r = (k.form == 2'd1) ? P_TERM : P_E;
      P_E:     r = P_SIGN;
      P_SIGN:  r = P_EXP;
      P_EXP:   r = P_TERM;
      default: r = P_DONE;
    endcase
    return r;
  endfunction

  // does the emission still produce anything after phase p
  function automatic logic more_after(input phase_t p, input kind_t k,
      input logic [CNT_W-1:0] ps, input logic [CNT_W-1:0] n, input logic [CNT_W-1:0] a,
      input logic [1:0] t, input logic lg);
    logic r;
    phase_t q;
    r = 1'b0;
    q = phase_after(p, k);
    for (int i = 0; i < 7; i++) begin
      case (q)
        P_DOT, P_E, P_SIGN: r = 1'b1;
        P_MID:  if (!lg && a != 0 && ps < n) r = 1'b1;
        P_EXP:  if (ps < n) r = 1'b1;
        P_TERM: if (t == 2'(T_SPACE)) r = 1'b1;
        default: ;
      endcase
      q = phase_after(q, k);
    end
    return r;
  endfunction

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; mode <= M_PLAIN; kind <= '0; dcount <= '0;
      hpend <= 1'b0; ovf <= 1'b0; wr_lo <= 1'b0;
    end else begin
      state <= state_next; mode <= mode_next; kind <= kind_next; dcount <= dcount_next;
      hpend <= hpend_next; ovf <= ovf_next; wr_lo <= wr_lo_next;
    end
  end

  always_ff @(posedge clk) begin
    sp_left <= sp_left_next; pair <= pair_next; lo_digit <= lo_digit_next;
    ph <= ph_next; pos <= pos_next; left <= left_next; term <= term_next;
    lit_go <= lit_go_next;
  end

  // emission phase step
  logic [CNT_W-1:0] cur_len;
  logic in_digits, digit_ok;
  assign in_digits = (ph == P_LEAD) || (ph == P_MID) || (ph == P_EXP);
  assign digit_ok  = (left != 0) && (pos < dcount);

  // next state logic
  always_comb begin
    state_next = state; mode_next = mode; kind_next = kind; dcount_next = dcount;
    hpend_next = hpend; ovf_next = ovf; wr_lo_next = wr_lo;
    sp_left_next = sp_left; pair_next = pair; lo_digit_next = lo_digit;
    ph_next = ph; pos_next = pos; left_next = left; term_next = term;
    lit_go_next = lit_go;
    cur_len = '0;
    if (wr_lo) begin
      dcount_next = (dcount < CNT_W'(MAX_DIGITS)) ? dcount + 1'b1 : dcount;
      ovf_next = ovf | (dcount >= CNT_W'(MAX_DIGITS));
      wr_lo_next = 1'b0;
    end
    case (state)
      S_IDLE: if (acc) begin
        if (in_ch.flush) begin
          mode_next = M_PLAIN; hpend_next = 1'b0;
          if (mode == M_BUFFER) begin
            state_next = S_FIN_RD; term_next = 2'(T_FLUSH);
          end
        end else if (b == 8'd10 || b == 8'd13 || b == 8'd26) begin
        end else begin
          case (mode)
            M_ESC: begin
              mode_next = M_PLAIN;
              if (b == 8'h20) mode_next = M_SPACES;
              else if (b == 8'h21) begin mode_next = M_STREAM; hpend_next = 1'b0; end
              else if (b != 8'h7D && b != 8'h45 && b != 8'h42 && b != 8'h62 &&
                       b != 8'h7E && b != 8'h2D) begin
                if (kind_lookup(b) != 4'hF) begin
                  kind_next = kind_lookup(b); dcount_next = '0; hpend_next = 1'b0;
                  ovf_next = 1'b0; mode_next = M_BUFFER;
                end else begin
                  sp_left_next = b; state_next = S_ESC_BYTE;
                end
              end
            end
            M_SPACES: begin
              mode_next = M_PLAIN;
              if (b > 8'h20) begin
                sp_left_next = b - 8'h20; state_next = S_SPACES;
              end
            end
            M_LITERAL: mode_next = M_PLAIN;
            M_STREAM, M_BUFFER: begin
              if (hpend || (b != 8'h20 && b != 8'h7E && b != 8'h7D)) begin
                hpend_next = 1'b0;
                if (mode == M_STREAM) begin
                  pair_next = pval; state_next = S_STR_HI;
                end else begin
                  dcount_next = (dcount < CNT_W'(MAX_DIGITS)) ? dcount + 1'b1 : dcount;
                  ovf_next = ovf | (dcount >= CNT_W'(MAX_DIGITS));
                  lo_digit_next = pones; wr_lo_next = 1'b1;
                end
              end else if (b == 8'h7D) begin
                hpend_next = 1'b1;
              end else if (mode == M_BUFFER) begin
                state_next = S_FIN_RD;
                term_next = (b == 8'h20) ? 2'(T_SPACE) : 2'(T_TILDE);
              end else if (b == 8'h20) begin
                mode_next = M_PLAIN; state_next = S_SPACES; sp_left_next = 8'd1;
              end else begin
                mode_next = M_ESC;
              end
            end
            default: mode_next = (b == 8'h7E) ? M_ESC : M_PLAIN;
          endcase
        end
      end
      S_SPACES: if (!busy) begin
        sp_left_next = (sp_left > 8'(RUN_MAX)) ? sp_left - 8'(RUN_MAX) : 8'd0;
        if (sp_left <= 8'(RUN_MAX)) state_next = S_IDLE;
      end
      S_ESC_BYTE: if (!busy) state_next = S_IDLE;
      S_STR_HI: if (!busy) state_next = S_STR_LO;
      S_STR_LO: if (!busy) state_next = S_IDLE;
      S_FIN_RD: begin
        ph_next = P_LEAD; pos_next = '0;
        left_next = phase_len(P_LEAD, kd, dcount, after);
        lit_go_next = kd.lit && (after == 0) && (term == 2'(T_TILDE));
        state_next = S_FIN_EMIT;
      end
      S_FIN_EMIT: if (!busy) begin
        if (in_digits && digit_ok) begin
          pos_next = pos + 1'b1; left_next = left - 1'b1;
        end else begin
          ph_next = phase_after(ph, kd);
          if (ph == P_MID && lit_go) ph_next = P_TERM;
          cur_len = phase_len(ph_next, kd, dcount, after);
          left_next = cur_len;
          if (ph == P_TERM || ph == P_DONE) state_next = S_FIN_TAIL;
        end
      end
      S_FIN_TAIL: begin
        state_next = S_IDLE; dcount_next = '0; hpend_next = 1'b0; ovf_next = 1'b0;
        mode_next = lit_go ? M_LITERAL : (term == 2'(T_TILDE)) ? M_ESC : M_PLAIN;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // output logic
  logic last_digit;
  always_comb begin
    cmd = '0; last = 1'b0; wr_en = 1'b0; wr_addr = dcount; wr_digit = ptens;
    rd_addr = pos_next; last_digit = 1'b0;
    if (wr_lo) begin
      wr_en = (dcount < CNT_W'(MAX_DIGITS)); wr_digit = lo_digit; wr_addr = dcount;
    end
    case (state)
      S_IDLE: begin
        if (acc && !in_ch.flush && mode == M_BUFFER && !wr_lo &&
            (hpend || (b != 8'h20 && b != 8'h7E && b != 8'h7D)) &&
            dcount < CNT_W'(MAX_DIGITS)) begin
          wr_en = 1'b1; wr_digit = ptens;
        end
        if (acc && !in_ch.flush && !(b == 8'd10 || b == 8'd13 || b == 8'd26)) begin
          cmd.cnt = 7'd1; cmd.ch = b; last = 1'b1;
          case (mode)
            M_ESC: begin
              if (b == 8'h7D) begin cmd.emit = 1'b1; cmd.ch = 8'h0A; end
              else if (b == 8'h45 || b == 8'h42 || b == 8'h62 || b == 8'h7E ||
                       b == 8'h2D) cmd.emit = 1'b1;
              else if (b != 8'h20 && b != 8'h21 && kind_lookup(b) == 4'hF) begin
                cmd.emit = 1'b1; cmd.ch = 8'h7E; last = 1'b0;
                // the byte itself follows from its own state
              end
            end
            M_LITERAL: cmd.emit = 1'b1;
            M_PLAIN:   cmd.emit = (b != 8'h7E);
            default: ;
          endcase
        end
      end
      S_SPACES: begin
        cmd.emit = 1'b1; cmd.ch = 8'h20;
        cmd.cnt = (sp_left > 8'(RUN_MAX)) ? RUN_MAX : sp_left[6:0];
        last = (sp_left <= 8'(RUN_MAX));
      end
      S_ESC_BYTE: begin
        cmd.emit = 1'b1; cmd.cnt = 7'd1; cmd.ch = sp_left; last = 1'b1;
      end
      S_STR_HI: begin
        cmd.emit = 1'b1; cmd.cnt = 7'd1;
        cmd.ch = 8'h30 | {4'd0, stens};
      end
      S_STR_LO: begin
        cmd.emit = 1'b1; cmd.cnt = 7'd1; last = 1'b1;
        cmd.ch = 8'h30 | {4'd0, sones};
      end
      S_FIN_EMIT: begin
        cmd.cnt = 7'd1; cmd.flag = ovf;
        if (in_digits && digit_ok) begin
          cmd.emit = 1'b1; cmd.use_digit = 1'b1; last_digit = 1'b1;
        end else begin
          case (ph)
            P_DOT:  begin cmd.emit = 1'b1; cmd.ch = 8'h2E; end
            P_E:    begin cmd.emit = 1'b1; cmd.ch = 8'h45; end
            P_SIGN: begin cmd.emit = 1'b1; cmd.ch = kd.sign; end
            P_TERM: begin
              cmd.emit = (term == 2'(T_SPACE)); cmd.ch = 8'h20; last = 1'b1;
            end
            default: ;
          endcase
          if (ph != P_TERM)
            last = cmd.emit && !more_after(ph, kd, pos, dcount, after, term, lit_go);
        end
        if (last_digit)
          last = ((left > 1) && (pos + 1'b1 < dcount)) ? 1'b0
               : !more_after(ph, kd, pos + 1'b1, dcount, after, term, lit_go);
        rd_addr = pos_next;
      end
      default: ;
    endcase
  end
endmodule

// ===== hw/rtl/tilde_escape_text_decompressor.sv =====
// a result item is registered and presented the cycle after its byte is accepted
// plain bytes: one per cycle if output is free; pairs wait while digits are stored or sent
// a finished number: set up, emit its characters phase by phase, then close
// input is held off while results of the previous byte leave or the output item waits
// reset: synchronous active high rst returns decoding to plain pass through
// ----------------------------------------------------------------------------
// tilde_escape_text_decompressor
// top level: controller plus datapath with digit store
// ----------------------------------------------------------------------------
module tilde_escape_text_decompressor import ted_pkg::*; #(
  parameter int MAX_DIGITS = 56
) (
  input logic       clk,
  input logic       rst,
  ted_in_if.sink    in_ch,
  ted_out_if.source out_ch
);
  logic             busy, wr_en, last;
  logic [CNT_W-1:0] wr_addr, rd_addr;
  logic [3:0]       wr_digit;
  emit_cmd_t        cmd;

  ted_ctrl #(.MAX_DIGITS(MAX_DIGITS)) u_ctrl (
    .clk(clk), .rst(rst), .in_ch(in_ch), .busy(busy), .wr_en(wr_en), .wr_addr(wr_addr),
    .wr_digit(wr_digit), .rd_addr(rd_addr), .cmd(cmd), .last(last)
  );

  ted_datapath #(.MAX_DIGITS(MAX_DIGITS)) u_dp (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_addr(wr_addr), .wr_digit(wr_digit),
    .rd_addr(rd_addr), .cmd(cmd), .last(last), .busy(busy), .out_ch(out_ch)
  );
endmodule

// ===== hw/rtl/ted_checker.sv =====
// ----------------------------------------------------------------------------
// ted_checker
// port level checks on the decompressor
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module ted_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic [6:0] repeat_count
);
  `ASSERT_CLK(a_cnt_nonzero, clk, rst, out_valid |-> repeat_count != 7'd0)
  `ASSERT_CLK(a_cnt_max, clk, rst, out_valid |-> repeat_count <= 7'd94)
  `ASSERT_CLK(a_run_spaces, clk, rst, (out_valid && repeat_count > 7'd1) |-> out_char == 8'h20)
  `ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_char))
endmodule

bind tilde_escape_text_decompressor ted_checker u_chk (
  .clk(clk), .rst(rst), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_char(out_ch.out_char), .repeat_count(out_ch.repeat_count)
);
